/* sv/csc_pkg.sv */
// Shared constants for the circle versus segment contact test.
package csc_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_CALC_WIDTH = 30;
    localparam int RADIUS_W = 15;
    localparam int RSQ_W = 2 * RADIUS_W;
    localparam int T_FRAC = 16;
    localparam int T_W = T_FRAC + 1;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd1600;
endpackage

/* sv/csc_if.sv */
// Channel interfaces for segment words, result words and the radius register.
interface csc_seg_if #(parameter int W = csc_pkg::COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic signed [W-1:0] seg_ax;
    logic signed [W-1:0] seg_ay;
    logic signed [W-1:0] seg_bx;
    logic signed [W-1:0] seg_by;
    logic is_last;
    modport source (output valid, center_x, center_y, seg_ax, seg_ay, seg_bx, seg_by,
                    is_last, input ready);
    modport sink (input valid, center_x, center_y, seg_ax, seg_ay, seg_bx, seg_by,
                  is_last, output ready);
endinterface

interface csc_res_if #(parameter int W = csc_pkg::COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [W-1:0] contact_x;
    logic signed [W-1:0] contact_y;
    logic hit;
    logic last;
    modport source (output valid, contact_x, contact_y, hit, last, input ready);
    modport sink (input valid, contact_x, contact_y, hit, last, output ready);
endinterface

interface csc_cfg_if;
    logic valid;
    logic ready;
    logic [csc_pkg::RADIUS_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* sv/circle_segment_collision.sv */
// Words pass the front stages, the 16-stage divider for t and the back-end stages.
// Throughput: one word per cycle while no result word waits untaken.
// A stalled output freezes every stage together, so nothing is lost.
// Reset clears all valid bits and sets the radius to 1600 coordinate units (integer).
// The radius channel is always ready; radius squared is registered from the radius.
// Top level of the circle versus segment contact test.
module circle_segment_collision #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    csc_seg_if.sink   seg,
    csc_cfg_if.sink   cfg,
    csc_res_if.source result
);
    import csc_pkg::*;

    localparam int CW = (COORD_WIDTH > MAX_CALC_WIDTH) ? MAX_CALC_WIDTH : COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int AW = (DW + 1 > RADIUS_W + 2) ? DW + 1 : RADIUS_W + 2;
    localparam int MW = T_W + 1 + DW;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic onseg;
        logic hit_a;
        logic hit_b;
        logic t_one;
        logic last;
    } div_pl_t;

    logic en;
    logic out_valid_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RSQ_W-1:0] rsq_reg;

    assign en = !out_valid_reg || result.ready;
    assign seg.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            rsq_reg <= RSQ_W'(RADIUS_RESET) * RSQ_W'(RADIUS_RESET);
        end
        else
        begin
            if (cfg.valid)
            begin
                radius_reg <= cfg.data;
            end
            rsq_reg <= RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
        end
    end

    function automatic logic [AW-1:0] mag_of(input logic signed [DW-1:0] e);
        logic signed [AW-1:0] w;
        w = AW'(e);
        return (w < 0) ? AW'(-w) : AW'(w);
    endfunction

    // Stage 1: capture the word.
    logic v1_reg, last1_reg;
    logic signed [CW-1:0] cx1_reg, cy1_reg, ax1_reg, ay1_reg, bx1_reg, by1_reg;

    // Stage 2: differences.
    logic v2_reg, last2_reg;
    logic signed [CW-1:0] cx2_reg, cy2_reg, ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg, eax2_reg, eay2_reg, ebx2_reg, eby2_reg;

    // Stage 3: products and endpoint magnitudes.
    logic v3_reg, last3_reg;
    logic signed [CW-1:0] cx3_reg, cy3_reg, ax3_reg, ay3_reg, bx3_reg, by3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic ina3_reg, inb3_reg;
    logic [RADIUS_W-1:0] max3_reg, may3_reg, mbx3_reg, mby3_reg;

    // Stage 4: dot product, squared length, endpoint squares.
    logic v4_reg, last4_reg;
    logic signed [CW-1:0] cx4_reg, cy4_reg, ax4_reg, ay4_reg, bx4_reg, by4_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg;
    logic signed [SW-1:0] num4_reg, den4_reg;
    logic ina4_reg, inb4_reg;
    logic [RSQ_W-1:0] sax4_reg, say4_reg, sbx4_reg, sby4_reg;

    logic [AW-1:0] mag_eax, mag_eay, mag_ebx, mag_eby;

    assign mag_eax = mag_of(eax2_reg);
    assign mag_eay = mag_of(eay2_reg);
    assign mag_ebx = mag_of(ebx2_reg);
    assign mag_eby = mag_of(eby2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= seg.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last1_reg <= seg.is_last;
            cx1_reg <= seg.center_x[CW-1:0];
            cy1_reg <= seg.center_y[CW-1:0];
            ax1_reg <= seg.seg_ax[CW-1:0];
            ay1_reg <= seg.seg_ay[CW-1:0];
            bx1_reg <= seg.seg_bx[CW-1:0];
            by1_reg <= seg.seg_by[CW-1:0];

            last2_reg <= last1_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;
            dx2_reg <= DW'(bx1_reg) - DW'(ax1_reg);
            dy2_reg <= DW'(by1_reg) - DW'(ay1_reg);
            eax2_reg <= DW'(cx1_reg) - DW'(ax1_reg);
            eay2_reg <= DW'(cy1_reg) - DW'(ay1_reg);
            ebx2_reg <= DW'(cx1_reg) - DW'(bx1_reg);
            eby2_reg <= DW'(cy1_reg) - DW'(by1_reg);

            last3_reg <= last2_reg;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;
            bx3_reg <= bx2_reg;
            by3_reg <= by2_reg;
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            p1_reg <= PW'(dx2_reg) * PW'(eax2_reg);
            p2_reg <= PW'(dy2_reg) * PW'(eay2_reg);
            p3_reg <= PW'(dx2_reg) * PW'(dx2_reg);
            p4_reg <= PW'(dy2_reg) * PW'(dy2_reg);
            ina3_reg <= (mag_eax <= AW'(radius_reg)) && (mag_eay <= AW'(radius_reg));
            inb3_reg <= (mag_ebx <= AW'(radius_reg)) && (mag_eby <= AW'(radius_reg));
            max3_reg <= mag_eax[RADIUS_W-1:0];
            may3_reg <= mag_eay[RADIUS_W-1:0];
            mbx3_reg <= mag_ebx[RADIUS_W-1:0];
            mby3_reg <= mag_eby[RADIUS_W-1:0];

            last4_reg <= last3_reg;
            cx4_reg <= cx3_reg;
            cy4_reg <= cy3_reg;
            ax4_reg <= ax3_reg;
            ay4_reg <= ay3_reg;
            bx4_reg <= bx3_reg;
            by4_reg <= by3_reg;
            dx4_reg <= dx3_reg;
            dy4_reg <= dy3_reg;
            num4_reg <= SW'(p1_reg) + SW'(p2_reg);
            den4_reg <= SW'(p3_reg) + SW'(p4_reg);
            ina4_reg <= ina3_reg;
            inb4_reg <= inb3_reg;
            sax4_reg <= RSQ_W'(max3_reg) * RSQ_W'(max3_reg);
            say4_reg <= RSQ_W'(may3_reg) * RSQ_W'(may3_reg);
            sbx4_reg <= RSQ_W'(mbx3_reg) * RSQ_W'(mbx3_reg);
            sby4_reg <= RSQ_W'(mby3_reg) * RSQ_W'(mby3_reg);
        end
    end

    // Divider entry: special cases of t and the endpoint decisions.
    div_pl_t div_in_pl, div_out_pl;
    logic [SW-1:0] div_rem;
    logic div_out_valid;
    logic [T_FRAC-1:0] div_q;

    always_comb
    begin
        div_in_pl.ax = ax4_reg;
        div_in_pl.ay = ay4_reg;
        div_in_pl.bx = bx4_reg;
        div_in_pl.by = by4_reg;
        div_in_pl.cx = cx4_reg;
        div_in_pl.cy = cy4_reg;
        div_in_pl.dx = dx4_reg;
        div_in_pl.dy = dy4_reg;
        div_in_pl.last = last4_reg;
        div_in_pl.hit_a = ina4_reg
            && ({1'b0, sax4_reg} + {1'b0, say4_reg} <= {1'b0, rsq_reg});
        div_in_pl.hit_b = inb4_reg
            && ({1'b0, sbx4_reg} + {1'b0, sby4_reg} <= {1'b0, rsq_reg});
        if (den4_reg == '0)
        begin
            div_in_pl.onseg = 1'b1;
            div_in_pl.t_one = 1'b0;
            div_rem = '0;
        end
        else
        begin
            div_in_pl.onseg = (num4_reg >= 0) && (num4_reg <= den4_reg);
            div_in_pl.t_one = num4_reg >= den4_reg;
            div_rem = ((num4_reg > 0) && (num4_reg < den4_reg)) ? num4_reg : '0;
        end
    end

    csc_div #(
        .RW(SW),
        .QW(T_FRAC),
        .PLW($bits(div_pl_t))
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(v4_reg),
        .in_rem(div_rem),
        .in_den(den4_reg),
        .in_pl(div_in_pl),
        .out_valid(div_out_valid),
        .out_q(div_q),
        .out_pl(div_out_pl)
    );

    // Back end: scale by t, closest point, distance test, select.
    logic [T_W-1:0] t_val;
    assign t_val = div_out_pl.t_one ? T_W'(1 << T_FRAC) : {1'b0, div_q};

    logic vm_reg, vr_reg, ve_reg, vs_reg;
    div_pl_t plm_reg, plr_reg, ple_reg, pls_reg;
    logic signed [MW-1:0] mx_reg, my_reg;
    logic signed [CW-1:0] pxr_reg, pyr_reg, pxe_reg, pye_reg, pxs_reg, pys_reg;
    logic ine_reg;
    logic [RADIUS_W-1:0] mpx_reg, mpy_reg;
    logic ins_reg;
    logic [RSQ_W-1:0] spx_reg, spy_reg;

    logic signed [MW-1:0] rx, ry;
    logic signed [DW-1:0] pxw, pyw, epx, epy;
    logic [AW-1:0] mag_px, mag_py;

    always_comb
    begin
        rx = (mx_reg + MW'(1 << (T_FRAC - 1))) >>> T_FRAC;
        ry = (my_reg + MW'(1 << (T_FRAC - 1))) >>> T_FRAC;
        pxw = DW'(plm_reg.ax) + rx[DW-1:0];
        pyw = DW'(plm_reg.ay) + ry[DW-1:0];
        // The offset from the center uses the closest point of the previous stage.
        epx = DW'(plr_reg.cx) - DW'(pxr_reg);
        epy = DW'(plr_reg.cy) - DW'(pyr_reg);
        mag_px = mag_of(epx);
        mag_py = mag_of(epy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            ve_reg <= 1'b0;
            vs_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= div_out_valid;
            vr_reg <= vm_reg;
            ve_reg <= vr_reg;
            vs_reg <= ve_reg;
            out_valid_reg <= vs_reg;
        end
    end

    logic signed [CW-1:0] cxo_reg, cyo_reg;
    logic hito_reg, lasto_reg;
    logic close_hit;

    assign close_hit = pls_reg.onseg && ins_reg
        && ({1'b0, spx_reg} + {1'b0, spy_reg} <= {1'b0, rsq_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plm_reg <= div_out_pl;
            mx_reg <= MW'(signed'({1'b0, t_val})) * MW'(div_out_pl.dx);
            my_reg <= MW'(signed'({1'b0, t_val})) * MW'(div_out_pl.dy);

            plr_reg <= plm_reg;
            pxr_reg <= pxw[CW-1:0];
            pyr_reg <= pyw[CW-1:0];

            ple_reg <= plr_reg;
            pxe_reg <= pxr_reg;
            pye_reg <= pyr_reg;
            ine_reg <= (mag_px <= AW'(radius_reg)) && (mag_py <= AW'(radius_reg));
            mpx_reg <= mag_px[RADIUS_W-1:0];
            mpy_reg <= mag_py[RADIUS_W-1:0];

            pls_reg <= ple_reg;
            pxs_reg <= pxe_reg;
            pys_reg <= pye_reg;
            ins_reg <= ine_reg;
            spx_reg <= RSQ_W'(mpx_reg) * RSQ_W'(mpx_reg);
            spy_reg <= RSQ_W'(mpy_reg) * RSQ_W'(mpy_reg);

            lasto_reg <= pls_reg.last;
            if (close_hit)
            begin
                cxo_reg <= pxs_reg;
                cyo_reg <= pys_reg;
                hito_reg <= 1'b1;
            end
            else if (pls_reg.hit_a)
            begin
                cxo_reg <= pls_reg.ax;
                cyo_reg <= pls_reg.ay;
                hito_reg <= 1'b1;
            end
            else if (pls_reg.hit_b)
            begin
                cxo_reg <= pls_reg.bx;
                cyo_reg <= pls_reg.by;
                hito_reg <= 1'b1;
            end
            else
            begin
                cxo_reg <= pxs_reg;
                cyo_reg <= pys_reg;
                hito_reg <= 1'b0;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.contact_x = COORD_WIDTH'(cxo_reg);
    assign result.contact_y = COORD_WIDTH'(cyo_reg);
    assign result.hit = hito_reg;
    assign result.last = lasto_reg;
endmodule

/* sv/csc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module csc_div #(
    parameter int RW = 63,
    parameter int QW = csc_pkg::T_FRAC,
    parameter int PLW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [RW-1:0] in_den,
    input  logic [PLW-1:0] in_pl,
    output logic          out_valid,
    output logic [QW-1:0] out_q,
    output logic [PLW-1:0] out_pl
);
    import csc_pkg::*;

    logic          v_reg   [QW];
    logic [RW-1:0] rem_reg [QW];
    logic [RW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [PLW-1:0] pl_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < QW; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [RW-1:0] rem_in;
        logic [RW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [PLW-1:0] pl_in;
        logic [RW:0]   shifted;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_in = in_rem;
            assign den_in = in_den;
            assign q_in = '0;
            assign pl_in = in_pl;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in = q_reg[k-1];
            assign pl_in = pl_reg[k-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign take = shifted >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? RW'(shifted - {1'b0, den_in}) : shifted[RW-1:0];
                den_reg[k] <= den_in;
                q_reg[k] <= {q_in[QW-2:0], take};
                pl_reg[k] <= pl_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_q = q_reg[QW-1];
    assign out_pl = pl_reg[QW-1];
endmodule

/* sv/csc_checker.sv */
// Port-level checks for the contact test, bound to the top level.
module csc_checker #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic cfg_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [COORD_WIDTH-1:0] out_x,
    input logic [COORD_WIDTH-1:0] out_y,
    input logic out_hit
);
    import csc_pkg::*;

    // Input back-pressure comes only from a result word that is not taken.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without an output stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)
                                       && $stable(out_hit)))
        else $error("result word changed while stalled");

    // Reset empties the pipeline: no result appears in the cycle after reset ends.
    a_no_early_result: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word right after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("radius channel not ready");
endmodule

bind circle_segment_collision csc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_csc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(seg.ready),
    .cfg_ready(cfg.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_x(result.contact_x),
    .out_y(result.contact_y),
    .out_hit(result.hit)
);

/* tb/csc_checker.sv */
// Checker that predicts contact results from accepted segment words and compares them.
module csc_scoreboard #(
    parameter int W = 16
) (
    input  logic clk,
    input  logic rst_n,
    csc_seg_if.sink   seg_mon,
    csc_cfg_if.sink   cfg_mon,
    csc_res_if.sink   res_mon,
    output int        errors,
    output int        pending
);
    typedef struct packed {
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic                hit;
        logic                last;
    } contact_t;

    contact_t contacts_due[$];
    logic [14:0] radius_q;
    int mismatch_cnt;

    function automatic bit near(longint ex, longint ey, longint r);
        longint ax, ay;
        ax = ex < 0 ? -ex : ex;
        ay = ey < 0 ? -ey : ey;
        if (ax > r || ay > r) return 0;
        return ex * ex + ey * ey <= r * r;
    endfunction

    function automatic longint round_scale(longint t, longint d);
        longint v;
        v = t * d + 32768;
        if (v >= 0) return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic contact_t predict_contact(longint cx, longint cy, longint ax,
                                                 longint ay, longint bx, longint by,
                                                 logic lst, longint r);
        longint dx, dy, num, den, t, px, py;
        bit onseg, h;
        contact_t c;
        dx = bx - ax;
        dy = by - ay;
        num = dx * (cx - ax) + dy * (cy - ay);
        den = dx * dx + dy * dy;
        t = 0;
        if (den == 0) onseg = 1;
        else begin
            onseg = num >= 0 && num <= den;
            if (num >= den) t = 65536;
            else if (num > 0) t = (num * 65536) / den;
        end
        px = ax + round_scale(t, dx);
        py = ay + round_scale(t, dy);
        h = onseg && near(cx - px, cy - py, r);
        if (!h) begin
            if (near(cx - ax, cy - ay, r))
            begin
                h = 1;
                px = ax;
                py = ay;
            end
            else if (near(cx - bx, cy - by, r))
            begin
                h = 1;
                px = bx;
                py = by;
            end
        end
        c.cx = px[W-1:0];
        c.cy = py[W-1:0];
        c.hit = h;
        c.last = lst;
        return c;
    endfunction

    assign errors = mismatch_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        contact_t want, got;
        if (!rst_n)
        begin
            radius_q <= 15'd1600;
            mismatch_cnt <= 0;
            contacts_due.delete();
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready) radius_q <= cfg_mon.data;
            if (seg_mon.valid && seg_mon.ready)
                contacts_due.push_back(predict_contact(seg_mon.center_x, seg_mon.center_y,
                    seg_mon.seg_ax, seg_mon.seg_ay, seg_mon.seg_bx, seg_mon.seg_by,
                    seg_mon.is_last, radius_q));
            if (res_mon.valid && res_mon.ready)
            begin
                got = {res_mon.contact_x, res_mon.contact_y, res_mon.hit, res_mon.last};
                if (contacts_due.size() == 0)
                begin
                    if (mismatch_cnt < 10) $display("result word with nothing expected");
                    mismatch_cnt <= mismatch_cnt + 1;
                end
                else
                begin
                    want = contacts_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_cnt < 10)
                            $display("mismatch: expected x=%0d y=%0d hit=%b last=%b, got x=%0d y=%0d hit=%b last=%b",
                                     want.cx, want.cy, want.hit, want.last,
                                     got.cx, got.cy, got.hit, got.last);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
        end
        pending = contacts_due.size();
    end
endmodule

/* tb/tb_circle_segment_collision.sv */
// Stimulus and verdict for the circle versus segment contact test.
module tb_circle_segment_collision;
    import csc_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int errors, pending;

    csc_seg_if #(16) seg ();
    csc_cfg_if cfg ();
    csc_res_if #(16) result ();

    circle_segment_collision #(.COORD_WIDTH(16)) uut (
        .clk(clk), .rst_n(rst_n), .seg(seg), .cfg(cfg), .result(result)
    );

    csc_scoreboard #(.W(16)) chk (
        .clk(clk), .rst_n(rst_n), .seg_mon(seg), .cfg_mon(cfg), .res_mon(result),
        .errors(errors), .pending(pending)
    );

    always #2 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random ready on the result side; the third radius phase never stalls.
    bit no_stall;
    always @(posedge clk)
    begin
        if (!rst_n || no_stall) result.ready <= 1'b1;
        else result.ready <= gap_len() == 0;
    end

    task automatic send_radius(logic [14:0] r);
        cfg.data <= r;
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_segment(logic [15:0] cx, logic [15:0] cy, logic [15:0] ax,
                                logic [15:0] ay, logic [15:0] bx, logic [15:0] by,
                                logic lst);
        int g;
        g = no_stall ? 0 : gap_len();
        if (g > 0)
        begin
            seg.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        seg.center_x <= cx;
        seg.center_y <= cy;
        seg.seg_ax <= ax;
        seg.seg_ay <= ay;
        seg.seg_bx <= bx;
        seg.seg_by <= by;
        seg.is_last <= lst;
        seg.valid <= 1'b1;
        do @(posedge clk); while (!seg.ready);
    endtask

    task automatic drain();
        seg.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // A random segment near the center, with full-range and end-on-center cases mixed in.
    task automatic random_segment();
        int sp;
        logic [15:0] cx, cy;
        cx = 16'($urandom);
        cy = 16'($urandom);
        sp = $urandom_range(0, 9);
        if (sp < 2)
            send_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 1'($urandom));
        else if (sp == 2)
            send_segment(cx, cy, cx + 16'($urandom_range(0, 4000)) - 16'd2000,
                         cy + 16'($urandom_range(0, 4000)) - 16'd2000, cx, cy,
                         1'($urandom));
        else
            send_segment(cx, cy, cx + 16'($urandom_range(0, 8000)) - 16'd4000,
                         cy + 16'($urandom_range(0, 8000)) - 16'd4000,
                         cx + 16'($urandom_range(0, 8000)) - 16'd4000,
                         cy + 16'($urandom_range(0, 8000)) - 16'd4000, 1'($urandom));
    endtask

    logic [14:0] radius_set [4] = '{15'd0, 15'd32767, 15'd1600, 15'd300};

    initial
    begin
        seg.valid = 0;
        seg.center_x = 0;
        seg.center_y = 0;
        seg.seg_ax = 0;
        seg.seg_ay = 0;
        seg.seg_bx = 0;
        seg.seg_by = 0;
        seg.is_last = 0;
        cfg.valid = 0;
        cfg.data = 0;
        no_stall = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: reset radius, extremes, zero length, vertical, beyond ends.
        send_segment(0, 0, 0, 0, 0, 0, 0);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1);
        send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        send_segment(100, 500, 0, -1000, 0, 1000, 0);
        send_segment(1700, 0, 0, -1000, 0, 1000, 1);
        send_segment(0, 3000, 0, -1000, 0, 1000, 0);
        send_segment(0, 2500, 0, -1000, 0, 1000, 0);
        send_segment(0, -2500, 0, -1000, 0, 1000, 0);
        send_segment(1600, 0, 0, 0, 0, 0, 1);
        send_segment(1601, 0, 0, 0, 0, 0, 0);
        send_segment(5, 7, -3, 2, 11, 9, 0);
        send_segment(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            send_radius(radius_set[ph]);
            no_stall = ph == 2;
            if (ph == 1)
            begin
                send_segment(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
                send_segment(0, 0, 16'h8000, 0, 16'h7fff, 0, 0);
            end
            repeat (125) random_segment();
            drain();
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
